FILE: rtl/core/lsij_pkg.sv
// Shared widths, codes and beat types for the line/segment intersection block.
package lsij_pkg;

  localparam int IN_W      = 32;
  localparam int DIF_W     = IN_W + 1;
  localparam int PR_W      = 2 * DIF_W;
  localparam int DN_W      = PR_W + 1;
  localparam int CC_W      = DN_W + 1;
  localparam int PT_W      = CC_W + IN_W;
  localparam int PS_W      = PT_W + 1;
  localparam int PT_SHIFT  = 16;
  localparam int PTN_W     = PS_W + PT_SHIFT;
  localparam int JP_W      = CC_W + PR_W;
  localparam int JAC_SHIFT = 32;
  localparam int JN_W      = JP_W + JAC_SHIFT;
  localparam int DN2_W     = 2 * DN_W;
  localparam int OUT_W     = 64;
  localparam int MUL_CW    = 16;
  localparam int THR_W     = 33;
  localparam int N_JAC     = 8;
  // abs, overflow check, one stage per quotient bit, round, increment, saturate
  localparam int DIV_LAT   = OUT_W + 5;

  localparam logic [THR_W-1:0] THR_RST = 33'd1;
  localparam logic [OUT_W-1:0] OUT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [OUT_W-1:0] OUT_MIN = 64'h8000_0000_0000_0000;

  typedef enum logic [1:0] {
    ST_PARALLEL = 2'd0,
    ST_MISS     = 2'd1,
    ST_HIT      = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [IN_W-1:0] line_ax;
    logic signed [IN_W-1:0] line_ay;
    logic signed [IN_W-1:0] line_bx;
    logic signed [IN_W-1:0] line_by;
    logic signed [IN_W-1:0] seg_start_x;
    logic signed [IN_W-1:0] seg_start_y;
    logic signed [IN_W-1:0] seg_end_x;
    logic signed [IN_W-1:0] seg_end_y;
  } in_item_t;

  typedef struct packed {
    status_e                 status;
    logic signed [OUT_W-1:0] point_x;
    logic signed [OUT_W-1:0] point_y;
    logic signed [OUT_W-1:0] dpx_d_start_x;
    logic signed [OUT_W-1:0] dpx_d_start_y;
    logic signed [OUT_W-1:0] dpx_d_end_x;
    logic signed [OUT_W-1:0] dpx_d_end_y;
    logic signed [OUT_W-1:0] dpy_d_start_x;
    logic signed [OUT_W-1:0] dpy_d_start_y;
    logic signed [OUT_W-1:0] dpy_d_end_x;
    logic signed [OUT_W-1:0] dpy_d_end_y;
  } res_item_t;

endpackage

FILE: rtl/core/lsij_delay.sv
// Fixed-length register delay line used to align side data with the math pipes.
module lsij_delay import lsij_pkg::*; #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  if (D == 0) begin : g_pass
    assign q_o = d_i;
  end else begin : g_line
    logic [W-1:0] sh_q [D];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        for (int i = 0; i < D; i++) sh_q[i] <= '0;
      end else begin
        sh_q[0] <= d_i;
        for (int i = 1; i < D; i++) sh_q[i] <= sh_q[i-1];
      end
    end

    assign q_o = sh_q[D-1];
  end

endmodule

FILE: rtl/core/lsij_mul.sv
// Pipelined signed multiplier: one narrow partial product of b per stage.
module lsij_mul import lsij_pkg::*; #(
  parameter int AW = 32,
  parameter int BW = 32,
  parameter int CW = MUL_CW
) (
  input  logic                 clk_i,
  input  logic signed [AW-1:0] a_i,
  input  logic signed [BW-1:0] b_i,
  output logic signed [AW+BW-1:0] p_o
);

  localparam int NS  = (BW + CW - 1) / CW;
  localparam int PW  = AW + BW;
  localparam int BXW = NS * CW;

  logic signed [AW-1:0]  a_q   [NS];
  logic signed [BXW-1:0] b_q   [NS];
  logic signed [PW-1:0]  acc_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_st
    logic signed [AW-1:0]  a_s;
    logic signed [BXW-1:0] b_s;
    logic signed [PW-1:0]  acc_s;
    logic signed [CW:0]    ck;
    logic signed [AW+CW:0] pp;

    if (k == 0) begin : g_first
      assign a_s   = a_i;
      assign b_s   = BXW'(b_i);
      assign acc_s = '0;
    end else begin : g_next
      assign a_s   = a_q[k-1];
      assign b_s   = b_q[k-1];
      assign acc_s = acc_q[k-1];
    end

    if (k == NS - 1) begin : g_top
      assign ck = {b_s[BXW-1], b_s[k*CW +: CW]};
    end else begin : g_low
      assign ck = {1'b0, b_s[k*CW +: CW]};
    end

    assign pp = a_s * ck;

    always_ff @(posedge clk_i) begin
      a_q[k]   <= a_s;
      b_q[k]   <= b_s;
      acc_q[k] <= acc_s + (PW'(pp) <<< (k * CW));
    end
  end

  assign p_o = acc_q[NS-1];

endmodule

FILE: rtl/core/lsij_div.sv
// Pipelined restoring divider, round half away from zero, saturate to 64 bits.
module lsij_div import lsij_pkg::*; #(
  parameter int NW = 64,
  parameter int DW = 64
) (
  input  logic                    clk_i,
  input  logic signed [NW-1:0]    num_i,
  input  logic        [DW-1:0]    den_i,
  input  logic                    neg_i,
  output logic signed [OUT_W-1:0] q_o
);

  localparam int QW = OUT_W;
  localparam int XW = ((NW > DW + QW) ? NW : DW + QW) + 1;

  logic [NW-1:0] mag_a_q;
  logic [DW-1:0] den_a_q;
  logic          sgn_a_q;

  logic [NW-1:0] rem_q [QW+1];
  logic [DW-1:0] den_q [QW+1];
  logic [QW-1:0] quo_q [QW+1];
  logic          sgn_q [QW+1];
  logic          ovf_q [QW+1];

  logic [QW-1:0] qr_q;
  logic          rb_q, sgr_q, ovr_q;
  logic [QW:0]   q65_q;
  logic          sgi_q, ovi_q;
  logic [QW-1:0] out_q;

  always_ff @(posedge clk_i) begin
    mag_a_q <= num_i[NW-1] ? NW'(~num_i + 1'b1) : NW'(num_i);
    den_a_q <= den_i;
    sgn_a_q <= num_i[NW-1] ^ neg_i;
    rem_q[0] <= mag_a_q;
    den_q[0] <= den_a_q;
    quo_q[0] <= '0;
    sgn_q[0] <= sgn_a_q;
    ovf_q[0] <= XW'(mag_a_q) >= (XW'(den_a_q) << QW);
  end

  for (genvar s = 0; s < QW; s++) begin : g_bit
    localparam int BI = QW - 1 - s;
    logic [XW-1:0] trial;

    assign trial = XW'(rem_q[s]) - (XW'(den_q[s]) << BI);

    always_ff @(posedge clk_i) begin
      den_q[s+1] <= den_q[s];
      sgn_q[s+1] <= sgn_q[s];
      ovf_q[s+1] <= ovf_q[s];
      if (!trial[XW-1]) begin
        rem_q[s+1]     <= trial[NW-1:0];
        quo_q[s+1]     <= quo_q[s] | (QW'(1) << BI);
      end else begin
        rem_q[s+1]     <= rem_q[s];
        quo_q[s+1]     <= quo_q[s];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    qr_q  <= quo_q[QW];
    rb_q  <= (XW'(rem_q[QW]) << 1) >= XW'(den_q[QW]);
    sgr_q <= sgn_q[QW];
    ovr_q <= ovf_q[QW];

    q65_q <= {1'b0, qr_q} + (QW+1)'(rb_q);
    sgi_q <= sgr_q;
    ovi_q <= ovr_q;

    if (ovi_q) begin
      out_q <= sgi_q ? OUT_MIN : OUT_MAX;
    end else if (sgi_q) begin
      out_q <= (q65_q > {1'b0, OUT_MIN}) ? OUT_MIN : (~q65_q[QW-1:0] + 1'b1);
    end else begin
      out_q <= (q65_q > {1'b0, OUT_MAX}) ? OUT_MAX : q65_q[QW-1:0];
    end
  end

  assign q_o = out_q;

endmodule

FILE: rtl/core/line_segment_intersect_jacobian.sv
// Top level: line/segment intersection point and Jacobian, fully pipelined.
//
//   channel   signals                          beat taken when
//   input     start_i, item_i, busy_o          start_i && !busy_o
//   result    done_o, result_o                 done_o (one cycle, no backpressure)
//   config    cfg_we_i, cfg_wdata_i            cfg_we_i
//
// One beat per cycle; the delay from an input edge to its result is set by
// five front stages, the 5-stage Jacobian multipliers and the 69-stage dividers.
// busy_o stays low: nothing in the pipe ever waits. Reset clears all valid bits
// and sets the threshold to 1.
module line_segment_intersect_jacobian import lsij_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  in_item_t         item_i,
  output logic             busy_o,
  output logic             done_o,
  output res_item_t        result_o,
  input  logic             cfg_we_i,
  input  logic [THR_W-1:0] cfg_wdata_i
);

  localparam int JLAT = (PR_W + MUL_CW - 1) / MUL_CW;
  localparam int PLAT = (IN_W + MUL_CW - 1) / MUL_CW;
  localparam int FLAT = JLAT + DIV_LAT - 1;

  logic [THR_W-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RST;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // front stages
  logic v0_q, v1_q, v2_q, v3_q, v4_q, v5_q;
  in_item_t it0_q;
  logic signed [DIF_W-1:0] lx1_q, ly1_q, dx1_q, dy1_q, wx1_q, wy1_q;
  logic signed [IN_W-1:0]  sx1_q, sy1_q, ex1_q, ey1_q;
  logic signed [PR_W-1:0]  pxx2_q, pxy2_q, pyx2_q, pyy2_q, pw1_q, pw2_q;
  logic signed [IN_W-1:0]  sx2_q, sy2_q, ex2_q, ey2_q;
  logic signed [DN_W-1:0]  dn3_q, nn3_q;
  logic signed [PR_W-1:0]  pxx3_q, pxy3_q, pyx3_q, pyy3_q;
  logic signed [IN_W-1:0]  sx3_q, sy3_q, ex3_q, ey3_q;
  logic signed [DN_W-1:0]  dn4_q, nn4_q;
  logic signed [CC_W-1:0]  cc4_q;
  logic        [DN_W-1:0]  dnm4_q;
  logic signed [PR_W-1:0]  pxx4_q, pxy4_q, pyx4_q, pyy4_q;
  logic signed [IN_W-1:0]  sx4_q, sy4_q, ex4_q, ey4_q;
  logic par5_q, hit5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v0_q <= start_i && !busy_o;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    it0_q <= item_i;

    lx1_q <= DIF_W'(it0_q.line_bx) - DIF_W'(it0_q.line_ax);
    ly1_q <= DIF_W'(it0_q.line_by) - DIF_W'(it0_q.line_ay);
    dx1_q <= DIF_W'(it0_q.seg_end_x) - DIF_W'(it0_q.seg_start_x);
    dy1_q <= DIF_W'(it0_q.seg_end_y) - DIF_W'(it0_q.seg_start_y);
    wx1_q <= DIF_W'(it0_q.line_ax) - DIF_W'(it0_q.seg_start_x);
    wy1_q <= DIF_W'(it0_q.line_ay) - DIF_W'(it0_q.seg_start_y);
    sx1_q <= it0_q.seg_start_x;
    sy1_q <= it0_q.seg_start_y;
    ex1_q <= it0_q.seg_end_x;
    ey1_q <= it0_q.seg_end_y;

    pxx2_q <= lx1_q * dx1_q;
    pxy2_q <= lx1_q * dy1_q;
    pyx2_q <= ly1_q * dx1_q;
    pyy2_q <= ly1_q * dy1_q;
    pw1_q  <= wx1_q * ly1_q;
    pw2_q  <= wy1_q * lx1_q;
    sx2_q  <= sx1_q;
    sy2_q  <= sy1_q;
    ex2_q  <= ex1_q;
    ey2_q  <= ey1_q;

    dn3_q  <= DN_W'(pyx2_q) - DN_W'(pxy2_q);
    nn3_q  <= DN_W'(pw1_q) - DN_W'(pw2_q);
    pxx3_q <= pxx2_q;
    pxy3_q <= pxy2_q;
    pyx3_q <= pyx2_q;
    pyy3_q <= pyy2_q;
    sx3_q  <= sx2_q;
    sy3_q  <= sy2_q;
    ex3_q  <= ex2_q;
    ey3_q  <= ey2_q;

    dn4_q  <= dn3_q;
    nn4_q  <= nn3_q;
    cc4_q  <= CC_W'(dn3_q) - CC_W'(nn3_q);
    dnm4_q <= dn3_q[DN_W-1] ? DN_W'(~dn3_q + 1'b1) : DN_W'(dn3_q);
    pxx4_q <= pxx3_q;
    pxy4_q <= pxy3_q;
    pyx4_q <= pyx3_q;
    pyy4_q <= pyy3_q;
    sx4_q  <= sx3_q;
    sy4_q  <= sy3_q;
    ex4_q  <= ex3_q;
    ey4_q  <= ey3_q;

    par5_q <= (dnm4_q == '0) || (dnm4_q < DN_W'(thr_q));
    hit5_q <= ((nn4_q == '0) || (nn4_q[DN_W-1] == dn4_q[DN_W-1])) &&
              ((cc4_q == '0) || (cc4_q[CC_W-1] == dn4_q[DN_W-1]));
  end

  // status flags ride alongside the math
  logic [2:0] flg_d;
  logic       vo, paro, hito;

  assign flg_d = {v5_q, par5_q, hit5_q};

  lsij_delay #(.W(3), .D(FLAT)) u_flg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .d_i    (flg_d),
    .q_o    ({vo, paro, hito})
  );

  // point numerators S*C + E*N
  logic signed [CC_W-1:0]   nn4_x;
  logic signed [PT_W-1:0]   pcx, pnx, pcy, pny;
  logic signed [PS_W-1:0]   psx_q, psy_q, psx_a, psy_a;

  assign nn4_x = CC_W'(nn4_q);

  lsij_mul #(.AW(CC_W), .BW(IN_W), .CW(MUL_CW)) u_mcx (
    .clk_i (clk_i), .a_i (cc4_q), .b_i (sx4_q), .p_o (pcx));
  lsij_mul #(.AW(CC_W), .BW(IN_W), .CW(MUL_CW)) u_mnx (
    .clk_i (clk_i), .a_i (nn4_x), .b_i (ex4_q), .p_o (pnx));
  lsij_mul #(.AW(CC_W), .BW(IN_W), .CW(MUL_CW)) u_mcy (
    .clk_i (clk_i), .a_i (cc4_q), .b_i (sy4_q), .p_o (pcy));
  lsij_mul #(.AW(CC_W), .BW(IN_W), .CW(MUL_CW)) u_mny (
    .clk_i (clk_i), .a_i (nn4_x), .b_i (ey4_q), .p_o (pny));

  always_ff @(posedge clk_i) begin
    psx_q <= PS_W'(pcx) + PS_W'(pnx);
    psy_q <= PS_W'(pcy) + PS_W'(pny);
  end

  lsij_delay #(.W(2 * PS_W), .D(JLAT - PLAT - 1)) u_pdl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .d_i    ({psx_q, psy_q}),
    .q_o    ({psx_a, psy_a})
  );

  logic [DN_W-1:0] dnm_a;
  logic            dng_a;

  lsij_delay #(.W(DN_W + 1), .D(JLAT)) u_ddl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .d_i    ({dnm4_q, dn4_q[DN_W-1]}),
    .q_o    ({dnm_a, dng_a})
  );

  logic signed [OUT_W-1:0] qpx, qpy;

  lsij_div #(.NW(PTN_W), .DW(DN_W)) u_divx (
    .clk_i (clk_i),
    .num_i ({psx_a, {PT_SHIFT{1'b0}}}),
    .den_i (dnm_a),
    .neg_i (dng_a),
    .q_o   (qpx)
  );

  lsij_div #(.NW(PTN_W), .DW(DN_W)) u_divy (
    .clk_i (clk_i),
    .num_i ({psy_a, {PT_SHIFT{1'b0}}}),
    .den_i (dnm_a),
    .neg_i (dng_a),
    .q_o   (qpy)
  );

  // Jacobian: L*D*K over Dn^2
  logic signed [DN2_W-1:0] dn2;

  lsij_mul #(.AW(DN_W), .BW(DN_W), .CW(MUL_CW)) u_msq (
    .clk_i (clk_i), .a_i (dn4_q), .b_i (dn4_q), .p_o (dn2));

  logic signed [OUT_W-1:0] qj [N_JAC];

  for (genvar e = 0; e < N_JAC; e++) begin : g_jac
    localparam int R = e / 4;
    localparam int C = e % 4;
    logic signed [CC_W-1:0] ka;
    logic signed [PR_W-1:0] lb;
    logic signed [JP_W-1:0] jp;

    if (C < 2) begin : g_c
      assign ka = cc4_q;
    end else begin : g_n
      assign ka = nn4_x;
    end

    if (R == 0) begin : g_rx
      assign lb = (C % 2 == 1) ? pxx4_q : pxy4_q;
    end else begin : g_ry
      assign lb = (C % 2 == 1) ? pyx4_q : pyy4_q;
    end

    lsij_mul #(.AW(CC_W), .BW(PR_W), .CW(MUL_CW)) u_mj (
      .clk_i (clk_i), .a_i (ka), .b_i (lb), .p_o (jp));

    lsij_div #(.NW(JN_W), .DW(DN2_W)) u_dj (
      .clk_i (clk_i),
      .num_i ({jp, {JAC_SHIFT{1'b0}}}),
      .den_i (DN2_W'(dn2)),
      .neg_i (C % 2 == 0),
      .q_o   (qj[e])
    );
  end

  // result beat
  logic      done_q;
  res_item_t res_q, res_d;

  always_comb begin
    res_d               = '0;
    res_d.status        = ST_PARALLEL;
    if (!paro) begin
      res_d.status        = hito ? ST_HIT : ST_MISS;
      res_d.point_x       = hito ? qpx : '0;
      res_d.point_y       = hito ? qpy : '0;
      res_d.dpx_d_start_x = qj[0];
      res_d.dpx_d_start_y = qj[1];
      res_d.dpx_d_end_x   = qj[2];
      res_d.dpx_d_end_y   = qj[3];
      res_d.dpy_d_start_x = qj[4];
      res_d.dpy_d_start_y = qj[5];
      res_d.dpy_d_end_x   = qj[6];
      res_d.dpy_d_end_y   = qj[7];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vo;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign busy_o   = 1'b0;
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

FILE: bench/lsij_checker.sv
// Checker: predicts each result from the input beat and compares it with the output.
module lsij_checker import lsij_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             busy_i,
  input  in_item_t         item_i,
  input  logic             done_i,
  input  res_item_t        result_i,
  input  logic             cfg_we_i,
  input  logic [THR_W-1:0] cfg_wdata_i,
  output int               pending_o,
  output int               failures_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BW = 256;
  typedef logic signed [BW-1:0] wide_t;
  typedef logic [OUT_W-1:0] field_arr_t [11];

  logic [THR_W-1:0] threshold;
  res_item_t        expected_q[$];
  string            field_name [11] = '{"status", "point_x", "point_y",
    "dpx_d_start_x", "dpx_d_start_y", "dpx_d_end_x", "dpx_d_end_y",
    "dpy_d_start_x", "dpy_d_start_y", "dpy_d_end_x", "dpy_d_end_y"};

  // round to nearest, ties away from zero, saturate to 64 bits
  function automatic logic [OUT_W-1:0] quot_round_sat(wide_t num, wide_t den);
    logic [BW-1:0] an, ad, q, r;
    logic          neg;
    neg = (num < 0) != (den < 0);
    an = (num < 0) ? -num : num;
    ad = (den < 0) ? -den : den;
    q = an / ad;
    r = an % ad;
    if ((r << 1) >= ad) q = q + 1;
    if (neg) begin
      if (q > {1'b0, OUT_MIN}) return OUT_MIN;
      return -q[OUT_W-1:0];
    end
    if (q > {1'b0, OUT_MAX}) return OUT_MAX;
    return q[OUT_W-1:0];
  endfunction

  function automatic res_item_t intersect_jacobian(in_item_t it, logic [THR_W-1:0] thr);
    res_item_t r;
    wide_t     ax, ay, sx, sy, ex, ey, lx, ly, dx, dy, dn, nn, cc, dn2, adn;
    logic      hit;
    r = '0;
    r.status = ST_PARALLEL;
    ax = wide_t'(it.line_ax);
    ay = wide_t'(it.line_ay);
    sx = wide_t'(it.seg_start_x);
    sy = wide_t'(it.seg_start_y);
    ex = wide_t'(it.seg_end_x);
    ey = wide_t'(it.seg_end_y);
    lx = wide_t'(it.line_bx) - ax;
    ly = wide_t'(it.line_by) - ay;
    dx = ex - sx;
    dy = ey - sy;
    dn = ly * dx - lx * dy;
    adn = (dn < 0) ? -dn : dn;
    if (dn == 0 || adn < wide_t'({1'b0, thr})) return r;
    nn = (ax - sx) * ly - (ay - sy) * lx;
    cc = dn - nn;
    hit = (nn == 0 || (nn < 0) == (dn < 0)) && (cc == 0 || (cc < 0) == (dn < 0));
    if (hit) begin
      r.status  = ST_HIT;
      r.point_x = quot_round_sat((sx * cc + ex * nn) <<< PT_SHIFT, dn);
      r.point_y = quot_round_sat((sy * cc + ey * nn) <<< PT_SHIFT, dn);
    end else begin
      r.status = ST_MISS;
    end
    dn2 = dn * dn;
    r.dpx_d_start_x = quot_round_sat((-lx * dy * cc) <<< JAC_SHIFT, dn2);
    r.dpx_d_start_y = quot_round_sat((lx * dx * cc) <<< JAC_SHIFT, dn2);
    r.dpx_d_end_x   = quot_round_sat((-lx * dy * nn) <<< JAC_SHIFT, dn2);
    r.dpx_d_end_y   = quot_round_sat((lx * dx * nn) <<< JAC_SHIFT, dn2);
    r.dpy_d_start_x = quot_round_sat((-ly * dy * cc) <<< JAC_SHIFT, dn2);
    r.dpy_d_start_y = quot_round_sat((ly * dx * cc) <<< JAC_SHIFT, dn2);
    r.dpy_d_end_x   = quot_round_sat((-ly * dy * nn) <<< JAC_SHIFT, dn2);
    r.dpy_d_end_y   = quot_round_sat((ly * dx * nn) <<< JAC_SHIFT, dn2);
    return r;
  endfunction

  function automatic field_arr_t unpack_fields(res_item_t r);
    field_arr_t f;
    f = '{r.status, r.point_x, r.point_y, r.dpx_d_start_x, r.dpx_d_start_y,
          r.dpx_d_end_x, r.dpx_d_end_y, r.dpy_d_start_x, r.dpy_d_start_y,
          r.dpy_d_end_x, r.dpy_d_end_y};
    return f;
  endfunction

  int mismatches = 0;

  initial begin
    threshold  = THR_RST;
    pending_o  = 0;
    failures_o = 0;
  end

  always @(posedge clk_i) begin
    field_arr_t want, got;
    res_item_t  exp_r;
    logic       bad;
    if (rst_ni) begin
      if (done_i) begin
        if (expected_q.size() == 0) begin
          failures_o++;
          if (mismatches++ < 10) $display("unexpected result beat at %0t", $realtime);
        end else begin
          exp_r = expected_q.pop_front();
          want = unpack_fields(exp_r);
          got  = unpack_fields(result_i);
          bad  = 1'b0;
          for (int k = 0; k < 11; k++) begin
            if (want[k] !== got[k]) begin
              bad = 1'b1;
              if (mismatches < 10)
                $display("mismatch %s: expected %h got %h", field_name[k], want[k], got[k]);
            end
          end
          if (bad) begin
            failures_o++;
            mismatches++;
          end
        end
      end
      if (start_i && !busy_i) expected_q.push_back(intersect_jacobian(item_i, threshold));
      if (cfg_we_i) threshold = cfg_wdata_i;
      pending_o = expected_q.size();
    end
  end

endmodule

FILE: bench/testbench.sv
// Top of the bench: clock, reset, stimulus phases, watchdog and verdict.
module testbench import lsij_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_WAIT  = 90;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start_i = 1'b0;
  in_item_t         item_i = '0;
  logic             cfg_we_i = 1'b0;
  logic [THR_W-1:0] cfg_wdata_i = '0;
  logic             busy_o, done_o;
  res_item_t        result_o;
  int               pending, failures;
  int               stall_cycles = 0;

  line_segment_intersect_jacobian DUT (
    .clk_i, .rst_ni, .start_i, .item_i, .busy_o, .done_o, .result_o,
    .cfg_we_i, .cfg_wdata_i
  );

  lsij_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .item_i, .done_i(done_o),
    .result_i(result_o), .cfg_we_i, .cfg_wdata_i,
    .pending_o(pending), .failures_o(failures)
  );

  initial forever #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o || cfg_we_i) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic in_item_t mk(int ax, int ay, int bx, int by,
                                  int sx, int sy, int ex, int ey);
    in_item_t it;
    it = '{ax, ay, bx, by, sx, sy, ex, ey};
    return it;
  endfunction

  function automatic int small_coord();
    return int'($urandom_range(0, 2 ** 21)) - 2 ** 20;
  endfunction

  function automatic int corner_coord();
    int pick;
    pick = $urandom_range(0, 4);
    case (pick)
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return 0;
      3: return -1;
      default: return 1;
    endcase
  endfunction

  function automatic in_item_t random_segment_pair();
    int kind, ax, ay, lx, ly, m, sx, sy, d;
    kind = $urandom_range(0, 9);
    if (kind < 5)
      return mk(small_coord(), small_coord(), small_coord(), small_coord(),
                small_coord(), small_coord(), small_coord(), small_coord());
    if (kind < 7)
      return mk($urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom);
    if (kind == 7) begin
      // parallel pair
      ax = small_coord(); ay = small_coord();
      lx = small_coord() >>> 4; ly = small_coord() >>> 4;
      m  = int'($urandom_range(0, 6)) - 3;
      sx = small_coord(); sy = small_coord();
      return mk(ax, ay, ax + lx, ay + ly, sx, sy, sx + m * lx, sy + m * ly);
    end
    if (kind == 8) begin
      // denominator near the threshold range
      d  = int'($urandom_range(0, 2 ** 18)) - 2 ** 17;
      sx = small_coord(); sy = small_coord();
      return mk(0, 0, 32'sh0001_0000, 0, sx, sy, sx + small_coord(), sy + d);
    end
    return mk(corner_coord(), corner_coord(), corner_coord(), corner_coord(),
              corner_coord(), corner_coord(), corner_coord(), corner_coord());
  endfunction

  task automatic send_beat(in_item_t it, int idle_pct);
    logic taken;
    while (int'($urandom_range(0, 99)) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    item_i  <= it;
    do begin
      @(negedge clk_i);
      taken = !busy_o;
      @(posedge clk_i);
    end while (!taken);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_phase(int count, int idle_pct);
    for (int n = 0; n < count; n++) send_beat(random_segment_pair(), idle_pct);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset threshold of one
    send_beat(mk(0, 0, 0, 0, 0, 0, 0, 0), 0);
    send_beat(mk(0, 0, 32'sh10000, 0, 0, -32'sh10000, 0, 32'sh10000), 0);
    send_beat(mk(0, 0, 32'sh10000, 0, 32'sh30000, 32'sh10000, 32'sh30000, 32'sh20000), 0);
    send_beat(mk(0, 0, 32'sh10000, 32'sh10000, 0, 0, 32'sh10000, 0), 0);
    send_beat(mk(0, 0, 32'sh10000, 32'sh10000, 32'sh20000, 0, 0, 32'sh20000), 0);
    send_beat(mk(0, 0, 32'sh10000, 0, 32'sh50000, 32'sh10000, 32'sh50000, 0), 0);
    send_beat(mk(0, 0, 32'sh10000, 0, 32'sh20000, 32'sh20000, 32'sh40000, 32'sh40000), 0);
    send_beat(mk(0, 0, 0, 1, 0, 0, 1, 0), 0);
    send_beat(mk(0, 0, 0, 1, 0, 5, 1, 5), 0);
    send_beat(mk(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF), 0);
    send_beat(mk(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFE, 32'sh8000_0000,
                 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0001), 0);
    send_beat(mk(0, 0, 1, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFE,
                 32'sh7FFF_FFFF), 0);
    send_beat(mk(-1, -1, -1, -1, -1, -1, -1, -1), 0);
    send_beat(mk(32'sh1234_5678, -32'sh0765_4321, -32'sh0abc_def0, 32'sh0fed_cba9,
                 -32'sh2222_2222, 32'sh3333_3333, 32'sh4444_4444, -32'sh5555_5555), 0);

    write_threshold('0);
    send_beat(mk(0, 0, 0, 0, 0, 0, 0, 0), 0);
    send_beat(mk(0, 0, 32'sh10000, 0, 0, 0, 32'sh20000, 0), 0);
    send_beat(mk(0, 0, 0, 1, 0, 0, 1, 0), 0);
    write_threshold(33'd2);
    send_beat(mk(0, 0, 0, 1, 0, 0, 1, 0), 0);
    send_beat(mk(0, 0, 0, 1, 0, 0, 2, 0), 0);
    write_threshold(33'h1_0000_0000);
    send_beat(mk(0, 0, 32'sh10000, 0, 0, 0, 0, -32'sh10000), 0);
    send_beat(mk(0, 0, 32'sh10000, 0, 0, 0, 0, 32'shFFFF), 0);
    random_phase(150, 27);

    write_threshold(33'h1_FFFF_FFFF);
    send_beat(mk(0, 0, 32'sh10000, 0, 0, 0, 0, 32'sh20000), 0);
    send_beat(mk(0, 0, 32'sh10000, 0, 0, 0, 0, 32'sh1FFFF), 0);
    random_phase(150, 84);

    write_threshold({1'b0, 32'($urandom)});
    random_phase(150, 0);

    drain();
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
